FILE: rtl/core/per_frame_bump_allocator_macros.svh
// assertion macros shared by the per-frame bump allocator modules
// expects a clk and an active-high synchronous rst in the module that uses them
`ifndef PER_FRAME_BUMP_ALLOCATOR_MACROS_SVH
`define PER_FRAME_BUMP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PFBA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PFBA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/pfba_pkg.sv
// shared types and constants for the per-frame bump allocator
// no dependencies
package pfba_pkg;

  localparam int DATA_W      = 32;
  localparam int KIND_W      = 2;
  localparam int SLOT_IDX_W  = 3;
  localparam int ALIGN_W     = 5;
  localparam int DEF_SLOT_COUNT = 2;

  localparam logic [DATA_W-1:0] CAP_RESET = 32'd65536;
  localparam logic [DATA_W-1:0] DATA_ONES = {DATA_W{1'b1}};

  // item kinds
  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // slot state as read for one item
  typedef struct packed {
    logic [DATA_W-1:0] cursor;
    logic [DATA_W-1:0] peak;
    logic [DATA_W-1:0] failed;
  } slot_rd_t;

  // slot state updates for one item, all at the slot on addr_a
  typedef struct packed {
    logic              act_we;
    logic              cursor_we;
    logic [DATA_W-1:0] cursor;
    logic              peak_we;
    logic [DATA_W-1:0] peak;
    logic              failed_we;
    logic [DATA_W-1:0] failed;
  } slot_wr_t;

  // one result item
  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] offset;
    logic [DATA_W-1:0] high_water;
    logic [DATA_W-1:0] overflow_count;
  } result_t;

endpackage

FILE: rtl/core/per_frame_bump_allocator.sv
// top level of the per-frame bump allocator: handshake, item and result registers
// depends on pfba_pkg, pfba_slot_file, pfba_alloc_calc, per_frame_bump_allocator_macros.svh
//
// usage
//   s_axis carries one command per transfer: begin frame, allocate or query
//   high-water mark, kind in tuser. every command gives exactly one result
//   transfer on m_axis, in order, with ok in tuser.
//   cfg_we / cfg_wdata write the per-slot capacity in bytes; write it only
//   while no command is in flight.
// pipeline
//   a command is held in the item register, decoded and applied to the slot
//   state in one pass, and its result is loaded into the result register
//   that drives m_axis. one command per cycle sustained while m_axis_tready
//   is high; the slot state updates in the same edge that loads the result,
//   so back-to-back commands see each other's effects.
// reset
//   rst clears all cursors, high-water marks and failure counters, makes
//   slot 0 current and loads the capacity with 65536.
// stalls
//   while m_axis_tready is low the result holds; one more command may wait
//   in the item register, after that s_axis_tready drops.
`include "per_frame_bump_allocator_macros.svh"

module per_frame_bump_allocator import pfba_pkg::*; #(
  parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  logic                 clk,
  input  logic                 rst,
  // command stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [39:0]          s_axis_tdata,   // slot_index[2:0], size[34:3], align_log2[39:35]
  input  logic [KIND_W-1:0]    s_axis_tuser,   // kind[1:0]
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [95:0]          m_axis_tdata,   // offset[31:0], high_water[63:32],
                                               // overflow_count[95:64]
  output logic                 m_axis_tuser,   // ok[0]
  // capacity register
  input  logic                 cfg_we,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // capacity register
  logic [DATA_W-1:0]     capacity;

  // item register
  logic                  in_valid;
  logic [KIND_W-1:0]     in_kind;
  logic [SLOT_IDX_W-1:0] in_slot;
  logic [DATA_W-1:0]     in_size;
  logic [ALIGN_W-1:0]    in_align;

  // result register
  logic                  out_valid;
  result_t               out_res;

  logic                  out_load;
  logic                  slot_ok;
  logic [SLOT_W-1:0]     slot_idx;
  logic [SLOT_W-1:0]     active;
  logic [SLOT_W-1:0]     addr_a;
  logic [SLOT_W-1:0]     addr_b;
  logic [DATA_W-1:0]     align_mask;
  slot_rd_t              rd;
  slot_wr_t              wr;
  result_t               res;

  // item moves on whenever the result register is free or being drained
  assign out_load      = in_valid & (~out_valid | m_axis_tready);
  assign s_axis_tready = ~in_valid | out_load;

  // slot addressing: begin frame works on its own slot, everything else on the
  // current one; a query reads the high-water mark of the named slot
  assign slot_ok  = ({1'b0, in_slot} < (SLOT_IDX_W + 1)'(SLOT_COUNT));
  assign slot_idx = in_slot[SLOT_W-1:0];
  assign addr_a   = ((in_kind == KIND_BEGIN) && slot_ok) ? slot_idx : active;
  assign addr_b   = (in_kind == KIND_QUERY) ? (slot_ok ? slot_idx : '0) : addr_a;

  pfba_slot_file #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slot_file (
    .clk    (clk),
    .rst    (rst),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .wr_en  (out_load),
    .wr     (wr),
    .rd     (rd),
    .active (active)
  );

  pfba_alloc_calc u_alloc_calc (
    .kind       (in_kind),
    .slot_ok    (slot_ok),
    .size       (in_size),
    .align_log2 (in_align),
    .capacity   (capacity),
    .rd         (rd),
    .wr         (wr),
    .res        (res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind  <= s_axis_tuser;
      in_slot  <= s_axis_tdata[2:0];
      in_size  <= s_axis_tdata[34:3];
      in_align <= s_axis_tdata[39:35];
    end
    if (out_load) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.ok;
  assign m_axis_tdata  = {out_res.overflow_count, out_res.high_water, out_res.offset};

  assign align_mask = ~(DATA_ONES << in_align);

  `PFBA_ASSERT(take_while_full, s_axis_tvalid && s_axis_tready && in_valid, out_load, "item register overrun")
  `PFBA_ASSERT(offset_aligned, out_load && res.ok && (in_kind == KIND_ALLOC), (res.offset & align_mask) == '0, "misaligned offset")
  `PFBA_ASSERT(offset_fits, out_load && res.ok && (in_kind == KIND_ALLOC), res.offset <= capacity, "offset beyond capacity")

endmodule

FILE: rtl/core/pfba_slot_file.sv
// per-slot cursor, high-water and failure counter storage plus the active slot
// depends on pfba_pkg and per_frame_bump_allocator_macros.svh
`include "per_frame_bump_allocator_macros.svh"

module pfba_slot_file import pfba_pkg::*; #(
  parameter int SLOT_COUNT = DEF_SLOT_COUNT,
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] addr_a,   // cursor, failure count, all writes
  input  logic [SLOT_W-1:0] addr_b,   // high-water read
  input  logic              wr_en,
  input  slot_wr_t          wr,
  output slot_rd_t          rd,
  output logic [SLOT_W-1:0] active
);

  logic [DATA_W-1:0] cursor [SLOT_COUNT];
  logic [DATA_W-1:0] peak   [SLOT_COUNT];
  logic [DATA_W-1:0] failed [SLOT_COUNT];

  assign rd.cursor = cursor[addr_a];
  assign rd.failed = failed[addr_a];
  assign rd.peak   = peak[addr_b];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        cursor[i] <= '0;
        peak[i]   <= '0;
        failed[i] <= '0;
      end
    end else if (wr_en) begin
      if (wr.act_we) begin
        active <= addr_a;
      end
      if (wr.cursor_we) begin
        cursor[addr_a] <= wr.cursor;
      end
      if (wr.peak_we) begin
        peak[addr_a] <= wr.peak;
      end
      if (wr.failed_we) begin
        failed[addr_a] <= wr.failed;
      end
    end
  end

  `PFBA_ASSERT(active_in_range, 1'b1, int'(active) < SLOT_COUNT, "active slot out of range")

  for (genvar gi = 0; gi < SLOT_COUNT; gi++) begin : g_chk
    `PFBA_ASSERT(cursor_below_peak, 1'b1, cursor[gi] <= peak[gi], "cursor above high-water")
    `PFBA_ASSERT_NXT(failed_monotonic, 1'b1, failed[gi] >= $past(failed[gi]), "failure count fell")
  end

endmodule

FILE: rtl/core/pfba_alloc_calc.sv
// align, fit test and state update for one item
// depends on pfba_pkg
module pfba_alloc_calc import pfba_pkg::*; (
  input  logic [KIND_W-1:0]  kind,
  input  logic               slot_ok,
  input  logic [DATA_W-1:0]  size,
  input  logic [ALIGN_W-1:0] align_log2,
  input  logic [DATA_W-1:0]  capacity,
  input  slot_rd_t           rd,
  output slot_wr_t           wr,
  output result_t            res
);

  logic              is_begin;
  logic              is_alloc;
  logic              is_query;
  logic [DATA_W-1:0] align_mask;
  logic [DATA_W:0]   aligned;
  logic [DATA_W+1:0] end_sum;
  logic              fits;
  logic              alloc_ok;
  logic              alloc_fail;
  logic [DATA_W-1:0] nc;
  logic              peak_up;
  logic              fail_inc;
  logic [DATA_W-1:0] failed_inc;

  assign is_begin = (kind == KIND_BEGIN);
  assign is_alloc = (kind == KIND_ALLOC);
  assign is_query = (kind == KIND_QUERY);

  // round up without wrap, then one add against capacity
  assign align_mask = ~(DATA_ONES << align_log2);
  assign aligned    = ({1'b0, rd.cursor} + {1'b0, align_mask}) & ~{1'b0, align_mask};
  assign end_sum    = {1'b0, aligned} + {2'b00, size};
  assign fits       = (end_sum <= {2'b00, capacity});

  assign alloc_ok   = is_alloc & fits;
  assign alloc_fail = is_alloc & ~fits;
  assign nc         = end_sum[DATA_W-1:0];
  assign peak_up    = alloc_ok & (nc > rd.peak);
  assign fail_inc   = alloc_fail & (rd.failed != DATA_ONES);
  assign failed_inc = rd.failed + 32'd1;

  always_comb begin
    wr.act_we    = is_begin & slot_ok;
    wr.cursor_we = (is_begin & slot_ok) | alloc_ok;
    wr.cursor    = is_begin ? '0 : nc;
    wr.peak_we   = peak_up;
    wr.peak      = nc;
    wr.failed_we = fail_inc;
    wr.failed    = failed_inc;

    res.ok     = alloc_ok | ((is_begin | is_query) & slot_ok);
    res.offset = alloc_ok ? aligned[DATA_W-1:0] : '0;
    if (is_query) begin
      res.high_water = slot_ok ? rd.peak : '0;
    end else begin
      res.high_water = peak_up ? nc : rd.peak;
    end
    res.overflow_count = fail_inc ? failed_inc : rd.failed;
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for per_frame_bump_allocator: directed and random command streams
// depends on pfba_pkg and the per_frame_bump_allocator rtl
module testbench;
  import pfba_pkg::*;

  localparam int SLOTS = DEF_SLOT_COUNT;
  // kind code that the block must treat as a no-op
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  // cycles without any transfer while work is pending before giving up
  localparam int STALL_LIMIT = 4000;
  // mismatch lines printed before going quiet, counting continues
  localparam int PRINT_CAP = 100;

  // one command as it travels on s_axis
  typedef struct packed {
    logic [ALIGN_W-1:0]    align_log2;
    logic [DATA_W-1:0]     size;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [KIND_W-1:0]     kind;
  } cmd_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata = '0;   // slot_index[2:0], size[34:3], align_log2[39:35]
  logic [KIND_W-1:0] s_axis_tuser = '0;   // kind[1:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [95:0]       m_axis_tdata;        // offset, high_water, overflow_count
  logic              m_axis_tuser;        // ok
  logic              cfg_we = 1'b0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  per_frame_bump_allocator #(
    .SLOT_COUNT(SLOTS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #2 clk = ~clk;

  // commands waiting to be driven and results the allocator still owes us
  cmd_t    cmd_queue[$];
  result_t owed_results[$];

  // shadow copy of the allocator state
  logic [DATA_W-1:0] shadow_capacity;
  logic [DATA_W-1:0] shadow_cursor[SLOTS];
  logic [DATA_W-1:0] shadow_peak[SLOTS];
  logic [DATA_W-1:0] shadow_fails[SLOTS];
  int                shadow_active;

  // idling controls, percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  logic        cmd_taken = 1'b0;
  int          error_count = 0;
  int          idle_cycles = 0;
  int          cmds_sent = 0;
  int          results_seen = 0;
  int          fit_count = 0;
  int          miss_count = 0;
  int          cap_writes = 0;
  int          useful_cmds = 0;
  logic [31:0] phase_cap = CAP_RESET;

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < PRINT_CAP)
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // bump allocation on the shadow state; returns the result the block should give
  function automatic result_t apply_command(cmd_t c);
    result_t     r;
    logic [63:0] align;
    logic [63:0] aligned;
    logic [63:0] cap;
    int          s;
    r = '0;
    s = shadow_active;
    case (c.kind)
      KIND_BEGIN: begin
        if (c.slot_index < SLOTS) begin
          shadow_active = c.slot_index;
          shadow_cursor[c.slot_index] = '0;
          r.ok = 1'b1;
        end
      end
      KIND_ALLOC: begin
        // round the cursor up without wrapping, then check against capacity
        align = 64'd1 << c.align_log2;
        aligned = ({32'd0, shadow_cursor[s]} + align - 64'd1) & ~(align - 64'd1);
        cap = {32'd0, shadow_capacity};
        if (aligned <= cap && {32'd0, c.size} <= cap - aligned) begin
          shadow_cursor[s] = aligned[31:0] + c.size;
          if (shadow_cursor[s] > shadow_peak[s])
            shadow_peak[s] = shadow_cursor[s];
          r.ok = 1'b1;
          r.offset = aligned[31:0];
          fit_count++;
        end else begin
          // failure counter saturates
          if (shadow_fails[s] != DATA_ONES)
            shadow_fails[s] = shadow_fails[s] + 1;
          miss_count++;
        end
      end
      default: ;
    endcase
    s = shadow_active;
    if (c.kind == KIND_QUERY) begin
      if (c.slot_index < SLOTS) begin
        r.ok = 1'b1;
        r.high_water = shadow_peak[c.slot_index];
      end
    end else begin
      r.high_water = shadow_peak[s];
    end
    r.overflow_count = shadow_fails[s];
    return r;
  endfunction

  // driver: present the next command at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || cmd_taken) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd_t c;
        c = cmd_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c.align_log2, c.size, c.slot_index};
        s_axis_tuser  <= c.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: track config writes, check results, predict accepted commands
  always @(posedge clk) begin
    cmd_taken <= s_axis_tvalid && s_axis_tready && !rst;
    if (rst) begin
      shadow_capacity = CAP_RESET;
      shadow_active = 0;
      for (int i = 0; i < SLOTS; i++) begin
        shadow_cursor[i] = '0;
        shadow_peak[i] = '0;
        shadow_fails[i] = '0;
      end
    end else begin
      if (cfg_we)
        shadow_capacity = cfg_wdata;
      // results are older than any command taken at this edge, so check first
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          flag_mismatch("unexpected result", m_axis_tdata[31:0], '0);
        end else begin
          result_t want;
          want = owed_results.pop_front();
          if (m_axis_tuser !== want.ok)
            flag_mismatch("ok", {31'd0, m_axis_tuser}, {31'd0, want.ok});
          if (m_axis_tdata[31:0] !== want.offset)
            flag_mismatch("offset", m_axis_tdata[31:0], want.offset);
          if (m_axis_tdata[63:32] !== want.high_water)
            flag_mismatch("high_water", m_axis_tdata[63:32], want.high_water);
          if (m_axis_tdata[95:64] !== want.overflow_count)
            flag_mismatch("overflow_count", m_axis_tdata[95:64], want.overflow_count);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cmd_t c;
        c.align_log2 = s_axis_tdata[39:35];
        c.size       = s_axis_tdata[34:3];
        c.slot_index = s_axis_tdata[2:0];
        c.kind       = s_axis_tuser;
        owed_results.push_back(apply_command(c));
        cmds_sent++;
      end
      // watchdog only runs while there is work outstanding
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cmd_queue.size() == 0 && !s_axis_tvalid && owed_results.size() == 0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == STALL_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
          $display("testbench: errors");
          $finish;
        end
      end
    end
  end

  task automatic push_cmd(logic [KIND_W-1:0] kind, logic [SLOT_IDX_W-1:0] slot,
                          logic [DATA_W-1:0] size, logic [ALIGN_W-1:0] lg);
    cmd_t c;
    c.kind = kind;
    c.slot_index = slot;
    c.size = size;
    c.align_log2 = lg;
    cmd_queue.push_back(c);
    // ignored commands do not count toward the random budget
    if (kind != KIND_SPARE && !(kind == KIND_BEGIN && slot >= SLOTS))
      useful_cmds++;
  endtask

  // block until the allocator has nothing in flight; checked at the rising edge
  // where the queue and tvalid are settled
  task automatic wait_drained();
    while (cmd_queue.size() != 0 || s_axis_tvalid || owed_results.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(logic [DATA_W-1:0] value);
    wait_drained();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    phase_cap = value;
    cap_writes++;
  endtask

  // a frame: begin on a slot, then mostly allocations with some queries and noise
  task automatic add_frame();
    int          n;
    int          r;
    logic [31:0] lim;
    logic [31:0] size;
    logic [4:0]  lg;
    lim = phase_cap >> 3;
    if ($urandom_range(9) != 0)
      push_cmd(KIND_BEGIN, SLOT_IDX_W'($urandom_range(SLOTS - 1)), $urandom(),
               ALIGN_W'($urandom()));
    else
      push_cmd(KIND_BEGIN, SLOT_IDX_W'($urandom_range(7)), $urandom(),
               ALIGN_W'($urandom()));
    n = $urandom_range(12, 3);
    repeat (n) begin
      r = $urandom_range(99);
      size = ($urandom_range(9) != 0) ? $urandom_range(lim) : $urandom();
      lg = ALIGN_W'(($urandom_range(4) != 0) ? $urandom_range(6) : $urandom_range(31));
      if (r < 65)
        push_cmd(KIND_ALLOC, SLOT_IDX_W'($urandom_range(7)), size, lg);
      else if (r < 85)
        push_cmd(KIND_QUERY,
                 SLOT_IDX_W'(($urandom_range(4) == 0) ? $urandom_range(7)
                                                      : $urandom_range(SLOTS - 1)),
                 $urandom(), ALIGN_W'($urandom()));
      else
        push_cmd(KIND_W'($urandom()), SLOT_IDX_W'($urandom()), $urandom(),
                 ALIGN_W'($urandom()));
    end
  endtask

  initial begin
    logic [31:0] caps[5];
    int          target;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed: reset capacity, alignment edges, overflow, out-of-range slots
    push_cmd(KIND_BEGIN, 3'd0, 32'd0, 5'd0);
    push_cmd(KIND_ALLOC, 3'd0, 32'd0, 5'd0);            // zero size at cursor 0
    push_cmd(KIND_ALLOC, 3'd0, 32'd1, 5'd0);
    push_cmd(KIND_ALLOC, 3'd0, 32'd3, 5'd4);            // rounds up to 16
    push_cmd(KIND_ALLOC, 3'd0, 32'd5, 5'd31);           // alignment past capacity
    push_cmd(KIND_ALLOC, 3'd0, DATA_ONES, 5'd0);        // far too large
    push_cmd(KIND_QUERY, 3'd0, 32'd0, 5'd0);
    push_cmd(KIND_QUERY, 3'd1, 32'd0, 5'd0);
    push_cmd(KIND_QUERY, 3'd7, 32'd0, 5'd0);            // out-of-range query
    push_cmd(KIND_BEGIN, 3'd5, 32'd0, 5'd0);            // out-of-range begin
    push_cmd(KIND_SPARE, 3'd7, DATA_ONES, 5'd31);       // unused kind, all bits set
    push_cmd(KIND_BEGIN, 3'd1, 32'd0, 5'd0);
    push_cmd(KIND_ALLOC, 3'd0, CAP_RESET, 5'd16);       // fills the slot exactly
    push_cmd(KIND_ALLOC, 3'd0, 32'd0, 5'd0);            // zero size right at the end
    push_cmd(KIND_ALLOC, 3'd0, 32'd1, 5'd0);
    push_cmd(KIND_QUERY, 3'd1, 32'd0, 5'd0);
    // zero capacity: only zero-size requests at cursor 0 fit
    set_capacity(32'd0);
    push_cmd(KIND_BEGIN, 3'd0, 32'd0, 5'd0);
    push_cmd(KIND_ALLOC, 3'd0, 32'd0, 5'd0);
    push_cmd(KIND_ALLOC, 3'd0, 32'd1, 5'd0);
    push_cmd(KIND_ALLOC, 3'd0, 32'd0, 5'd3);
    // full capacity: offsets near the top of the address range
    set_capacity(DATA_ONES);
    push_cmd(KIND_BEGIN, 3'd1, 32'd0, 5'd0);
    push_cmd(KIND_ALLOC, 3'd0, DATA_ONES, 5'd0);
    push_cmd(KIND_ALLOC, 3'd0, 32'd0, 5'd0);
    push_cmd(KIND_ALLOC, 3'd0, 32'd0, 5'd1);            // rounding would wrap
    push_cmd(KIND_QUERY, 3'd1, 32'd0, 5'd0);

    // random frames under three idling patterns and several capacities each
    for (int mode = 0; mode < 3; mode++) begin
      caps[0] = $urandom_range(256, 1);
      caps[1] = 32'd1;
      caps[2] = DATA_ONES;
      caps[3] = $urandom_range(32'h0010_0000, 32'h0000_1000);
      caps[4] = $urandom();
      for (int k = 0; k < 5; k++) begin
        set_capacity(caps[k]);
        send_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 85 : 0;
        recv_stall_pct = (mode == 0) ? 85 : (mode == 1) ? 34 : 0;
        target = useful_cmds + 90;
        while (useful_cmds < target)
          add_frame();
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    $display("covered %0d commands, %0d results, %0d capacity writes",
             cmds_sent, results_seen, cap_writes);
    $display("allocations that fit: %0d, that overflowed: %0d, mismatches: %0d",
             fit_count, miss_count, error_count);
    if (error_count == 0 && owed_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
